// ----- rtl/dmx_pkg.sv -----
// dmx_pkg: shared types, codes and helpers for the distributed mutex node.
// No dependencies; imported by dmx_front, dmx_back and the top module.
package dmx_pkg;

  // Fixed field widths
  localparam int OP_W        = 2;
  localparam int KIND_W      = 2;
  localparam int ID_W        = 4;
  localparam int SEQ_PORT_W  = 16;
  localparam int NCOUNT_W    = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  // Parameter defaults
  localparam int MAX_NODES_DEF = 16;
  localparam int SEQ_BITS_DEF  = 16;
  localparam int CMDQ_DEPTH    = 2;
  localparam int OUTQ_DEPTH    = 2;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_REQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_REL  = 2'd1;
  localparam logic [OP_W-1:0] OP_PREQ = 2'd2;
  localparam logic [OP_W-1:0] OP_PREP = 2'd3;

  // Result message kinds
  localparam logic [KIND_W-1:0] MSG_REQ   = 2'd0;
  localparam logic [KIND_W-1:0] MSG_REPLY = 2'd1;
  localparam logic [KIND_W-1:0] MSG_GRANT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ID     = 1'd1;

  typedef struct packed {
    logic [NCOUNT_W-1:0] node_count;
    logic [ID_W-1:0]     own_id;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] peer_id;
  } cmd_hdr_t;

  typedef struct packed {
    logic [KIND_W-1:0]     msg_kind;
    logic [ID_W-1:0]       dest_node;
    logic [SEQ_PORT_W-1:0] seq_num;
    logic                  last;
  } res_t;

  // Group size: node_count clamped to 1..max_nodes (max_nodes <= 64).
  function automatic logic [6:0] group_size(input logic [NCOUNT_W-1:0] nc,
                                            input int max_nodes);
    logic [6:0] n;
    n = 7'(nc);
    if (n == 7'd0) n = 7'd1;
    if (32'(n) > max_nodes) n = 7'(max_nodes);
    return n;
  endfunction

endpackage

// ----- rtl/dmx_fifo.sv -----
// dmx_fifo: small flop-based FIFO used for the command and result queues.
// Depends on nothing but its parameters.
module dmx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + 1'b1)
    else $error("fifo count did not grow on write");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    do_rd && !do_wr |=> count == $past(count) - 1'b1)
    else $error("fifo count did not shrink on read");

endmodule

// ----- rtl/dmx_front.sv -----
// dmx_front: takes input beats, drops foreign peer messages, saturates the
// peer sequence number and queues commands. Uses dmx_pkg.
module dmx_front #(
  parameter int MAX_NODES = 16,
  parameter int SEQ_BITS  = 16
) (
  input  dmx_pkg::cfg_t                   cfg,
  input  logic                            push,
  output logic                            full,
  input  logic [dmx_pkg::OP_W-1:0]        op,
  input  logic [dmx_pkg::ID_W-1:0]        peer_id,
  input  logic [dmx_pkg::SEQ_PORT_W-1:0]  peer_seq,
  input  logic                            cmdq_full,
  output logic                            cmd_push,
  output dmx_pkg::cmd_hdr_t               cmd_hdr,
  output logic [SEQ_BITS-1:0]             cmd_seq
);
  import dmx_pkg::*;

  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

  logic [6:0] grp;
  logic       is_peer;
  logic       foreign;

  assign grp     = group_size(cfg.node_count, MAX_NODES);
  assign is_peer = (op == OP_PREQ) || (op == OP_PREP);
  assign foreign = is_peer &&
                   ((peer_id == cfg.own_id) || (32'(peer_id) >= 32'(grp)));

  assign full     = cmdq_full;
  assign cmd_push = push && !cmdq_full && !foreign;

  assign cmd_hdr.op      = op;
  assign cmd_hdr.peer_id = peer_id;

  always_comb begin
    if (64'(peer_seq) > 64'(SEQ_MAX)) begin
      cmd_seq = SEQ_MAX;
    end else begin
      cmd_seq = SEQ_BITS'(peer_seq);
    end
  end

endmodule

// ----- rtl/dmx_back.sv -----
// dmx_back: protocol state and sequencer; executes queued commands and
// emits one result per cycle while the queue has room. Uses dmx_pkg.
module dmx_back #(
  parameter int MAX_NODES = 16,
  parameter int SEQ_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dmx_pkg::cfg_t           cfg,
  input  logic                    cmd_valid,
  input  dmx_pkg::cmd_hdr_t       cmd_hdr,
  input  logic [SEQ_BITS-1:0]     cmd_seq,
  output logic                    cmd_pop,
  input  logic                    res_full,
  output logic                    res_push,
  output dmx_pkg::res_t           res
);
  import dmx_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam logic [SEQ_BITS-1:0]  SEQ_MAX = '1;
  localparam logic [MAX_NODES-1:0] ONE_HOT = MAX_NODES'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REQ  = 2'd1;
  localparam logic [1:0] ST_REL  = 2'd2;

  logic [1:0]           state, state_next;
  logic                 requesting, requesting_next;
  logic [SEQ_BITS-1:0]  own_seq, own_seq_next;
  logic [SEQ_BITS-1:0]  highest_seen, highest_seen_next;
  logic [NODE_W-1:0]    replies_owed, replies_owed_next;
  logic [MAX_NODES-1:0] held_back, held_back_next;
  logic [NODE_W-1:0]    idx, idx_next;
  logic [NODE_W-1:0]    sent, sent_next;

  logic [6:0]           grp;
  logic [SEQ_BITS-1:0]  seq_inc;
  logic [MAX_NODES-1:0] own_onehot;
  logic [MAX_NODES-1:0] idx_onehot;
  logic [MAX_NODES-1:0] pid_onehot;
  logic                 own_hit;
  logic                 defer;
  logic                 req_last;

  assign grp        = group_size(cfg.node_count, MAX_NODES);
  assign seq_inc    = (highest_seen == SEQ_MAX) ? SEQ_MAX : highest_seen + 1'b1;
  assign own_onehot = ONE_HOT << cfg.own_id;
  assign idx_onehot = ONE_HOT << idx;
  assign pid_onehot = ONE_HOT << cmd_hdr.peer_id;
  assign own_hit    = (32'(idx) == 32'(cfg.own_id));
  assign req_last   = (7'(sent) == grp - 7'd2);
  // Peer is deferred only while requesting and with a larger (sequence, id) pair
  assign defer      = requesting &&
                      ((cmd_seq > own_seq) ||
                       ((cmd_seq == own_seq) && (cmd_hdr.peer_id > cfg.own_id)));

  always_comb begin
    state_next        = state;
    requesting_next   = requesting;
    own_seq_next      = own_seq;
    highest_seen_next = highest_seen;
    replies_owed_next = replies_owed;
    held_back_next    = held_back;
    idx_next          = idx;
    sent_next         = sent;
    cmd_pop           = 1'b0;
    res_push          = 1'b0;
    res               = '0;

    unique case (state)
      ST_IDLE: begin
        // every command emits at most one beat here, so wait for room first
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd_hdr.op)
            OP_REQ: begin
              requesting_next   = 1'b1;
              own_seq_next      = seq_inc;
              replies_owed_next = NODE_W'(grp - 7'd1);
              if (grp == 7'd1) begin
                res_push      = 1'b1;
                res.msg_kind  = MSG_GRANT;
                res.dest_node = cfg.own_id;
                res.seq_num   = SEQ_PORT_W'(seq_inc);
                res.last      = 1'b1;
              end else begin
                state_next = ST_REQ;
                idx_next   = '0;
                sent_next  = '0;
              end
            end
            OP_REL: begin
              requesting_next = 1'b0;
              held_back_next  = held_back & ~own_onehot;
              idx_next        = '0;
              state_next      = ST_REL;
            end
            OP_PREQ: begin
              if (cmd_seq > highest_seen) begin
                highest_seen_next = cmd_seq;
              end
              if (defer) begin
                held_back_next = held_back | pid_onehot;
              end else begin
                res_push      = 1'b1;
                res.msg_kind  = MSG_REPLY;
                res.dest_node = cmd_hdr.peer_id;
                res.seq_num   = SEQ_PORT_W'(own_seq);
                res.last      = 1'b1;
              end
            end
            OP_PREP: begin
              if (requesting && (replies_owed != '0)) begin
                replies_owed_next = replies_owed - 1'b1;
                if (replies_owed == NODE_W'(1)) begin
                  res_push      = 1'b1;
                  res.msg_kind  = MSG_GRANT;
                  res.dest_node = cfg.own_id;
                  res.seq_num   = SEQ_PORT_W'(own_seq);
                  res.last      = 1'b1;
                end
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_REQ: begin
        if (own_hit) begin
          idx_next = idx + 1'b1;
        end else if (!res_full) begin
          res_push      = 1'b1;
          res.msg_kind  = MSG_REQ;
          res.dest_node = ID_W'(idx);
          res.seq_num   = SEQ_PORT_W'(own_seq);
          res.last      = req_last;
          idx_next      = idx + 1'b1;
          sent_next     = sent + 1'b1;
          if (req_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_REL: begin
        if (held_back == '0) begin
          state_next = ST_IDLE;
        end else if ((held_back & idx_onehot) != '0) begin
          if (!res_full) begin
            held_back_next = held_back & ~idx_onehot;
            res_push       = 1'b1;
            res.msg_kind   = MSG_REPLY;
            res.dest_node  = ID_W'(idx);
            res.seq_num    = SEQ_PORT_W'(own_seq);
            res.last       = (held_back_next == '0);
            idx_next       = idx + 1'b1;
            if (held_back_next == '0) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      requesting   <= 1'b0;
      own_seq      <= '0;
      highest_seen <= '0;
      replies_owed <= '0;
      held_back    <= '0;
      idx          <= '0;
      sent         <= '0;
    end else begin
      state        <= state_next;
      requesting   <= requesting_next;
      own_seq      <= own_seq_next;
      highest_seen <= highest_seen_next;
      replies_owed <= replies_owed_next;
      held_back    <= held_back_next;
      idx          <= idx_next;
      sent         <= sent_next;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == ST_IDLE)
    else $error("command taken while walking");

  a_req_done: assert property (@(posedge clk) disable iff (rst)
    res_push && res.last && state == ST_REQ |=> state == ST_IDLE)
    else $error("request walk did not end on final beat");

  a_rel_clears: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd_hdr.op == OP_REL |=> !requesting)
    else $error("release left request flag set");

endmodule

// ----- rtl/distributed_mutex_node_top.sv -----
// distributed_mutex_node_top: one Ricart-Agrawala mutual exclusion node.
// Instantiates dmx_front, dmx_fifo and dmx_back; uses dmx_pkg.
//
// Usage: input beats go in through push/full, result beats come out through
// empty/pop, both with queue semantics. Each input beat is one event: local
// request, local release, peer request or peer reply. Peer messages whose
// sender equals own_id or is outside the group are dropped at the front. A
// peer request or reply that causes a beat passes through the command queue
// and is written into the result queue when the sequencer takes it from
// there. A local request is taken from the command queue, then walks node
// indexes one per cycle, holding at a peer while the result queue is full,
// and emits one request beat per peer, skipping the own index; a release
// walks the held-back bitmap the same way. The sequencer in dmx_back writes
// at most one beat per cycle into the result queue. A two-entry command queue
// sits between the front and the sequencer, and a two-entry result queue at
// the output, so input is taken while results wait to be popped. The last
// port marks the final beat caused by one input event. Configuration
// (node_count, own_id) is written through cfg_write/cfg_index/cfg_data and
// must only change while the node is idle.
module distributed_mutex_node_top #(
  parameter int MAX_NODES = dmx_pkg::MAX_NODES_DEF,
  parameter int SEQ_BITS  = dmx_pkg::SEQ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [dmx_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dmx_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input events
  input  logic                              push,
  output logic                              full,
  input  logic [dmx_pkg::OP_W-1:0]          op,
  input  logic [dmx_pkg::ID_W-1:0]          peer_id,
  input  logic [dmx_pkg::SEQ_PORT_W-1:0]    peer_seq,
  // results
  output logic                              empty,
  input  logic                              pop,
  output logic [dmx_pkg::KIND_W-1:0]        msg_kind,
  output logic [dmx_pkg::ID_W-1:0]          dest_node,
  output logic [dmx_pkg::SEQ_PORT_W-1:0]    seq_num,
  output logic                              last
);
  import dmx_pkg::*;

  localparam int CMD_W = $bits(cmd_hdr_t) + SEQ_BITS;
  localparam int RES_W = $bits(res_t);

  cfg_t                cfg;

  // front to command queue
  logic                cmd_push;
  cmd_hdr_t            front_hdr;
  logic [SEQ_BITS-1:0] front_seq;
  logic                cmdq_full;

  // command queue to back
  logic [CMD_W-1:0]    cmdq_rd;
  logic                cmdq_empty;
  logic                cmd_pop;
  cmd_hdr_t            back_hdr;
  logic [SEQ_BITS-1:0] back_seq;

  // back to result queue
  logic                res_push;
  res_t                res_in;
  logic                res_full;
  res_t                res_out;

  // Configuration registers; writes beyond the list do not occur (1-bit index)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count <= NCOUNT_W'(2);
      cfg.own_id     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NODE_COUNT: cfg.node_count <= cfg_data;
        CFG_OWN_ID:     cfg.own_id     <= cfg_data[ID_W-1:0];
        default:        cfg.own_id     <= cfg.own_id;
      endcase
    end
  end

  dmx_front #(
    .MAX_NODES (MAX_NODES),
    .SEQ_BITS  (SEQ_BITS)
  ) u_front (
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .op        (op),
    .peer_id   (peer_id),
    .peer_seq  (peer_seq),
    .cmdq_full (cmdq_full),
    .cmd_push  (cmd_push),
    .cmd_hdr   (front_hdr),
    .cmd_seq   (front_seq)
  );

  dmx_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data ({front_hdr, front_seq}),
    .full    (cmdq_full),
    .rd_en   (cmd_pop),
    .rd_data (cmdq_rd),
    .empty   (cmdq_empty)
  );

  assign back_hdr = cmd_hdr_t'(cmdq_rd[CMD_W-1:SEQ_BITS]);
  assign back_seq = cmdq_rd[SEQ_BITS-1:0];

  dmx_back #(
    .MAX_NODES (MAX_NODES),
    .SEQ_BITS  (SEQ_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cmdq_empty),
    .cmd_hdr   (back_hdr),
    .cmd_seq   (back_seq),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  dmx_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign msg_kind  = res_out.msg_kind;
  assign dest_node = res_out.dest_node;
  assign seq_num   = res_out.seq_num;
  assign last      = res_out.last;

endmodule
